@@ rtl/mdcc_pkg.sv @@
package mdcc_pkg;

	localparam int OUT_W       = 24;
	localparam int RUN_W       = 16;
	localparam int SCALE_W     = 16;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 2;

	localparam int DEF_LEN_BITS    = 24;
	localparam int DEF_QUEUE_DEPTH = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROSE_MIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_SCALE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PARA_SCALE = 2'd3;

	localparam logic [OUT_W-1:0]   RST_MIN_SAMPLE = 24'd4096;
	localparam logic [RUN_W-1:0]   RST_PROSE_MIN  = 16'd200;
	localparam logic [SCALE_W-1:0] RST_LINK_SCALE = 16'd2560;
	localparam logic [SCALE_W-1:0] RST_PARA_SCALE = 16'd2048;

	// "](htt", oldest byte in the top
	localparam logic [39:0] TAIL_HEAD = 40'h5D28687474;
	localparam logic [7:0]  CH_P      = 8'h70;
	localparam logic [7:0]  CH_NL     = 8'h0A;
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	typedef struct packed {
		logic [OUT_W-1:0]   min_sample;
		logic [RUN_W-1:0]   prose_min;
		logic [SCALE_W-1:0] link_scale;
		logic [SCALE_W-1:0] para_scale;
	} cfg_t;

endpackage

@@ rtl/mdcc_if.sv @@
interface mdcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface mdcc_out_if import mdcc_pkg::*;;
	logic             valid;
	logic             ready;
	logic             chrome_dominated;
	logic [OUT_W-1:0] doc_bytes;
	logic [OUT_W-1:0] tail_count;
	logic [OUT_W-1:0] prose_count;

	modport source (output valid, output chrome_dominated, output doc_bytes,
		output tail_count, output prose_count, input ready);
	modport sink (input valid, input chrome_dominated, input doc_bytes,
		input tail_count, input prose_count, output ready);
endinterface

@@ rtl/mdcc_front.sv @@
module mdcc_front import mdcc_pkg::*; #(
	parameter int LEN_BITS = DEF_LEN_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mdcc_in_if.sink               in_ch,
	input  cfg_t                  cfg,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [3*LEN_BITS-1:0] q_data
);

	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	logic [39:0]         window_q;
	logic [LEN_BITS-1:0] byte_count_q;
	logic [LEN_BITS-1:0] link_count_q;
	logic [LEN_BITS-1:0] para_count_q;
	logic [RUN_W-1:0]    run_q;

	logic [LEN_BITS-1:0] cnt_nx, link_nx, para_nx;
	logic [RUN_W-1:0]    run_inc, run_nx, closing;
	logic                is_nl, accept;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_nl       = (in_ch.text_byte == CH_NL);

	always_comb begin
		cnt_nx  = (byte_count_q == LEN_MAX) ? byte_count_q : byte_count_q + 1'b1;
		link_nx = link_count_q;
		if (window_q == TAIL_HEAD && in_ch.text_byte == CH_P && link_count_q != LEN_MAX)
			link_nx = link_count_q + 1'b1;
		run_inc = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
		run_nx  = is_nl ? '0 : run_inc;
		// a newline closes the old run; the last word closes the one it extends
		if (is_nl)
			closing = run_q;
		else if (in_ch.last_byte)
			closing = run_inc;
		else
			closing = '0;
		para_nx = para_count_q;
		if (closing != '0 && closing >= cfg.prose_min && para_count_q != LEN_MAX)
			para_nx = para_count_q + 1'b1;
	end

	assign q_push = accept && in_ch.last_byte;
	assign q_data = {cnt_nx, link_nx, para_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			byte_count_q <= '0;
			link_count_q <= '0;
			para_count_q <= '0;
			run_q        <= '0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				window_q     <= '0;
				byte_count_q <= '0;
				link_count_q <= '0;
				para_count_q <= '0;
				run_q        <= '0;
			end else begin
				window_q     <= {window_q[31:0], in_ch.text_byte};
				byte_count_q <= cnt_nx;
				link_count_q <= link_nx;
				para_count_q <= para_nx;
				run_q        <= run_nx;
			end
		end
	end

endmodule

@@ rtl/mdcc_queue.sv @@
module mdcc_queue import mdcc_pkg::*; #(
	parameter int WIDTH = 3 * DEF_LEN_BITS,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/mdcc_back.sv @@
module mdcc_back import mdcc_pkg::*; #(
	parameter int LEN_BITS = DEF_LEN_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_not_empty,
	input  logic [3*LEN_BITS-1:0] q_data,
	output logic                  q_pop,
	mdcc_out_if.source            out_ch
);

	localparam int PW = LEN_BITS + SCALE_W;
	localparam int XW = (LEN_BITS > OUT_W) ? LEN_BITS : OUT_W;

	logic [LEN_BITS-1:0] cnt_in, link_in, para_in;

	logic                valid_s1;
	logic [LEN_BITS-1:0] cnt_s1, link_s1, para_s1;
	logic [PW-1:0]       lprod_s1, pprod_s1;
	logic                short_s1;

	logic             valid_q;
	logic             chrome_q;
	logic [OUT_W-1:0] total_q, link_q, para_q;

	logic          adv_out, load_s1, links_high, paras_low;
	logic [XW-1:0] cnt_x, link_x, para_x;

	assign {cnt_in, link_in, para_in} = q_data;

	assign adv_out = !valid_q || out_ch.ready;
	assign load_s1 = !valid_s1 || adv_out;
	assign q_pop   = q_not_empty && load_s1;

	// stage 1: products, registered before the compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= q_pop;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cnt_s1   <= cnt_in;
			link_s1  <= link_in;
			para_s1  <= para_in;
			lprod_s1 <= PW'(link_in) * PW'(cfg.link_scale);
			pprod_s1 <= PW'(para_in) * PW'(cfg.para_scale);
			short_s1 <= XW'(cnt_in) < XW'(cfg.min_sample);
		end
	end

	assign links_high = lprod_s1 > PW'(cnt_s1);
	assign paras_low  = pprod_s1 < PW'(cnt_s1);
	assign cnt_x      = XW'(cnt_s1);
	assign link_x     = XW'(link_s1);
	assign para_x     = XW'(para_s1);

	// output word; held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv_out)
			valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			if (short_s1) begin
				chrome_q <= 1'b0;
				total_q  <= '0;
				link_q   <= '0;
				para_q   <= '0;
			end else begin
				chrome_q <= links_high && paras_low;
				total_q  <= cnt_x[OUT_W-1:0];
				link_q   <= link_x[OUT_W-1:0];
				para_q   <= para_x[OUT_W-1:0];
			end
		end
	end

	assign out_ch.valid            = valid_q;
	assign out_ch.chrome_dominated = chrome_q;
	assign out_ch.doc_bytes        = total_q;
	assign out_ch.tail_count       = link_q;
	assign out_ch.prose_count      = para_q;

endmodule

@@ rtl/markdown_chrome_classifier_core.sv @@
// Markdown chrome classifier.
// in_ch carries a document one byte per word (text_byte, last_byte set on the
// final byte). While the hand-off queue is not full, a stream can run at one word
// per clock, documents back to back with no gap between them.
// out_ch gives one word per document: chrome_dominated plus length, link tail
// count and paragraph count (all zero when the document is shorter than the
// minimum sample size). The result passes through the hand-off queue, the
// multiply stage and the output register.
// The cfg_we/cfg_index/cfg_data port writes the four registers; write them only
// while no document is in flight.
// Reset clears the counters, the queue and the output, and loads the register
// defaults. When the receiver stalls, the output word holds, the queue fills,
// and in_ch.ready drops only once the queue holds QUEUE_DEPTH finished results;
// the per-byte counting carries on until then.
module markdown_chrome_classifier_core import mdcc_pkg::*; #(
	parameter int LEN_BITS    = DEF_LEN_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mdcc_in_if.sink               in_ch,
	mdcc_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;

	logic                  q_push, q_pop, q_full, q_not_empty;
	logic [3*LEN_BITS-1:0] q_wr_data, q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_sample <= RST_MIN_SAMPLE;
			cfg_q.prose_min  <= RST_PROSE_MIN;
			cfg_q.link_scale <= RST_LINK_SCALE;
			cfg_q.para_scale <= RST_PARA_SCALE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_SAMPLE: cfg_q.min_sample <= cfg_data[OUT_W-1:0];
				CFG_PROSE_MIN:  cfg_q.prose_min  <= cfg_data[RUN_W-1:0];
				CFG_LINK_SCALE: cfg_q.link_scale <= cfg_data[SCALE_W-1:0];
				CFG_PARA_SCALE: cfg_q.para_scale <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mdcc_front #(
		.LEN_BITS (LEN_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wr_data)
	);

	mdcc_queue #(
		.WIDTH (3 * LEN_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   (q_wr_data),
		.pop       (q_pop),
		.rd_data   (q_rd_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	mdcc_back #(
		.LEN_BITS (LEN_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_data      (q_rd_data),
		.q_pop       (q_pop),
		.out_ch      (out_ch)
	);

endmodule

@@ rtl/mdcc_checker.sv @@
module mdcc_checker import mdcc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             chrome_dominated,
	input logic [OUT_W-1:0] doc_bytes,
	input logic [OUT_W-1:0] tail_count,
	input logic [OUT_W-1:0] prose_count
);

	// nothing is offered out of reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// input back-pressure means a result word is already waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output word waiting");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(chrome_dominated) && $stable(doc_bytes)
			&& $stable(tail_count) && $stable(prose_count))
		else $error("output word changed while stalled");

endmodule

bind markdown_chrome_classifier_core mdcc_checker u_mdcc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.chrome_dominated (out_ch.chrome_dominated),
	.doc_bytes        (out_ch.doc_bytes),
	.tail_count       (out_ch.tail_count),
	.prose_count      (out_ch.prose_count)
);
